### src/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the sextet-to-character mapping.
// ----------------------------------------------------------------------------
package b64enc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned GROUP_W = 24;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CHAR_LOWER_OFS = 7'h47; // 'a' - 26
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_OFS = 7'h7C; // '0' - 52, mod 128
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;    // '+'
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;    // '/'
   localparam logic [CHAR_W-1:0] CHAR_PAD   = 7'h3D;    // '='

   localparam logic [5:0] SEXTET_MASK = 6'h3F;

   // one complete or final group handed from front to back
   typedef struct packed {
      logic [GROUP_W-1:0] grp;
      logic [1:0]         nbytes;   // 1..3 real bytes in grp
      logic               last;
   } grp_entry_type;

   function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
      logic [5:0]        s;
      logic [CHAR_W-1:0] c;
      s = v & SEXTET_MASK;
      if (s < 6'd26) begin
         c = {1'b0, s} + CHAR_UPPER_A;
      end else if (s < 6'd52) begin
         c = {1'b0, s} + CHAR_LOWER_OFS;
      end else if (s < 6'd62) begin
         c = {1'b0, s} + CHAR_DIGIT_OFS;
      end else if (s == 6'd62) begin
         c = CHAR_PLUS;
      end else begin
         c = CHAR_SLASH;
      end
      return c;
   endfunction

endpackage

### src/b64enc_front.sv
// ----------------------------------------------------------------------------
// b64enc_front
// Collects input bytes into groups of three and pushes finished groups.
// ----------------------------------------------------------------------------
module b64enc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,
   input  logic                         req_tlast,
   output logic                         push,
   output b64enc_pkg::grp_entry_type    push_entry,
   input  logic                         push_ready
);
   import b64enc_pkg::*;

   logic [15:0] pend_ff, pend_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        beat;
   logic        emit;

   assign req_tready = push_ready;
   assign beat       = req_tvalid & req_tready;
   assign emit       = req_tlast | cnt_ff[1];
   assign push       = beat & emit;

   always_comb begin
      push_entry.last = req_tlast;
      case (cnt_ff)
         2'd0: begin
            push_entry.grp    = {req_tdata, 16'h0000};
            push_entry.nbytes = 2'd1;
         end
         2'd1: begin
            push_entry.grp    = {pend_ff[15:8], req_tdata, 8'h00};
            push_entry.nbytes = 2'd2;
         end
         default: begin
            // a count of three is treated as two
            push_entry.grp    = {pend_ff, req_tdata};
            push_entry.nbytes = 2'd3;
         end
      endcase
   end

   always_comb begin
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      if (beat) begin
         if (emit) begin
            pend_in = 16'h0000;
            cnt_in  = 2'd0;
         end else if (cnt_ff == 2'd0) begin
            pend_in = {req_tdata, 8'h00};
            cnt_in  = 2'd1;
         end else begin
            pend_in = {pend_ff[15:8], req_tdata};
            cnt_in  = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 16'h0000;
         cnt_ff  <= 2'd0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

### src/b64enc_queue.sv
// ----------------------------------------------------------------------------
// b64enc_queue
// Small register queue of group entries between front and back.
// ----------------------------------------------------------------------------
module b64enc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  b64enc_pkg::grp_entry_type    push_entry,
   output logic                         push_ready,
   input  logic                         pop,
   output b64enc_pkg::grp_entry_type    pop_entry,
   output logic                         pop_valid
);
   import b64enc_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   grp_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_FULL);
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = mem_ff[rptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

### src/b64enc_back.sv
// ----------------------------------------------------------------------------
// b64enc_back
// Turns each group into four characters, one per cycle unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
module b64enc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   input  b64enc_pkg::grp_entry_type    pop_entry,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,
   output logic                         rsp_tlast
);
   import b64enc_pkg::*;

   grp_entry_type     cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic [1:0]        idx_ff, idx_in;
   logic              ovalid_ff, ovalid_in;
   logic [CHAR_W-1:0] ochar_ff, ochar_in;
   logic              olast_ff, olast_in;
   logic              step;
   logic [5:0]        sextet;
   logic [CHAR_W-1:0] ch;

   assign step = busy_ff & (~ovalid_ff | rsp_tready);
   // load a new group when idle or as the last character leaves
   assign pop  = ~busy_ff | (step & (idx_ff == 2'd3));

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = cur_ff.grp[23:18];
         2'd1:    sextet = cur_ff.grp[17:12];
         2'd2:    sextet = cur_ff.grp[11:6];
         default: sextet = cur_ff.grp[5:0];
      endcase
      ch = (idx_ff > cur_ff.nbytes) ? CHAR_PAD : sextet_char(sextet);
   end

   always_comb begin
      cur_in    = cur_ff;
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      ovalid_in = ovalid_ff;
      ochar_in  = ochar_ff;
      olast_in  = olast_ff;
      if (ovalid_ff & rsp_tready) begin
         ovalid_in = 1'b0;
      end
      if (step) begin
         ovalid_in = 1'b1;
         ochar_in  = ch;
         olast_in  = cur_ff.last & (idx_ff == 2'd3);
         idx_in    = idx_ff + 2'd1;
         if (idx_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
      if (pop & pop_valid) begin
         cur_in  = pop_entry;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         idx_ff    <= 2'd0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         idx_ff    <= idx_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      ochar_ff <= ochar_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {1'b0, ochar_ff};
   assign rsp_tlast  = olast_ff;

endmodule

### src/base64_stream_encoder.sv
// a group's closing byte is written into the group queue, the back part loads it, and
// its first character is registered; throughput: 4 characters per group at 1 character
// per cycle while the output does not stall; the back part's serializer sets that rate
// reset: synchronous, active high; clears held bytes, the group queue and the output
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with padding; front groups bytes, back emits characters.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [6:0] out_char, [7] zero
   output logic       rsp_tlast     // end_of_text
);
   import b64enc_pkg::*;

   logic          push, push_ready, pop, pop_valid;
   grp_entry_type push_entry, pop_entry;

   b64enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid)
   );

   b64enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### test/b64_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64_stream_checker
// Watches both stream channels of the base64 encoder. It tracks the held
// bytes of the current group, predicts the four characters of every group
// that closes, and compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module b64_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // final_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // [6:0] out_char, [7] zero
   input  logic       rsp_tlast,    // end_of_text
   output int         fail_count,
   output int         outstanding,
   output int         chars_checked
);

   typedef struct packed {
      logic [6:0] ch;
      logic       eot;
   } b64_char_type;

   b64_char_type expected_chars[$];
   logic [15:0] held_bytes;     // first byte in [15:8], second in [7:0]
   logic [1:0]  held_count;

   initial begin
      fail_count    = 0;
      chars_checked = 0;
      outstanding   = 0;
      held_bytes    = '0;
      held_count    = '0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] checker: %s", $realtime, msg);
      fail_count = fail_count + 1;
   endtask

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [6:0] b64_symbol(input logic [5:0] s);
      logic [7:0] c;
      if (s <= 6'd25) begin
         c = 8'h41 + s;
      end else if (s <= 6'd51) begin
         c = 8'h61 + s - 8'd26;
      end else if (s <= 6'd61) begin
         c = 8'h30 + s - 8'd52;
      end else if (s == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c[6:0];
   endfunction

   task automatic take_byte(input logic [7:0] b, input logic fin);
      logic [23:0]  grp;
      logic [2:0]   nbytes;
      logic [5:0]   sx;
      b64_char_type c;
      int           k;
      if (!fin && held_count < 2'd2) begin
         if (held_count == 2'd0) begin
            held_bytes = {b, 8'h00};
         end else begin
            held_bytes[7:0] = b;
         end
         held_count = held_count + 2'd1;
      end else begin
         case (held_count)
            2'd0: begin
               grp = {b, 16'h0000};
            end
            2'd1: begin
               grp = {held_bytes[15:8], b, 8'h00};
            end
            default: begin
               grp = {held_bytes, b};
            end
         endcase
         nbytes = (held_count > 2'd2) ? 3'd3 : {1'b0, held_count} + 3'd1;
         for (k = 0; k < 4; k++) begin
            sx    = grp[18 - 6 * k +: 6];
            c.ch  = (k <= nbytes) ? b64_symbol(sx) : b64enc_pkg::CHAR_PAD;
            c.eot = fin && (k == 3);
            expected_chars.insert(expected_chars.size(), c);
         end
         held_bytes = '0;
         held_count = '0;
      end
   endtask

   task automatic check_char();
      b64_char_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch($sformatf("unexpected character beat 0x%h last %b",
                                   rsp_tdata, rsp_tlast));
      end else begin
         want = expected_chars.pop_front();
         if (rsp_tdata[6:0] !== want.ch) begin
            report_mismatch($sformatf("char %0d: got 0x%h expected 0x%h",
                                      chars_checked, rsp_tdata[6:0], want.ch));
         end
         if (rsp_tlast !== want.eot) begin
            report_mismatch($sformatf("char %0d: end flag %b expected %b",
                                      chars_checked, rsp_tlast, want.eot));
         end
         if (rsp_tdata[7] !== 1'b0) begin
            report_mismatch($sformatf("char %0d: pad bit of tdata is %b",
                                      chars_checked, rsp_tdata[7]));
         end
      end
      chars_checked = chars_checked + 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         held_bytes = '0;
         held_count = '0;
         outstanding <= 0;
      end else begin
         // pop before push: a group's characters never leave in its own cycle
         if (rsp_tvalid && rsp_tready) begin
            check_char();
         end
         if (req_tvalid && req_tready) begin
            take_byte(req_tdata, req_tlast);
         end
         outstanding <= expected_chars.size();
      end
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte messages into the base64 encoder under shifting idle mixes
// and one long output stall; the checker predicts and compares the output.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 200000;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] data_byte
   logic       req_tlast;    // final_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [6:0] out_char, [7] zero
   logic       rsp_tlast;    // end_of_text

   int fail_count;
   int outstanding;
   int chars_checked;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int cycle_count;
   int byte_count;
   int msg_count;

   base64_stream_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   b64_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .chars_checked (chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still due",
                  cycle_count, outstanding);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // output side: random back-pressure, or a counted hold-off when requested
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      byte_count = byte_count + 1;
      if (fin) begin
         msg_count = msg_count + 1;
      end
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      int k;
      for (k = 0; k < len; k++) begin
         send_byte(8'($urandom_range(0, 255)), k == len - 1);
      end
   endtask

   initial begin
      int phase;
      int phase_bytes;
      int len;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      hold_left     = 0;
      byte_count    = 0;
      msg_count     = 0;
      send_idle_pct = 33;
      recv_idle_pct = 49;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one leftover byte: two pads
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // two leftover bytes: one pad
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // last byte closes a group, all '+'
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      // full groups mid-message ('/', A-D, digits, letters), ends with two pads
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(8'hD3, 1'b0);
      send_byte(8'h5D, 1'b0);
      send_byte(8'hB7, 1'b0);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b0);
      send_byte(8'h69, 1'b1);
      // one full group then a single leftover
      send_byte(8'h9A, 1'b0);
      send_byte(8'hBC, 1'b0);
      send_byte(8'hDE, 1'b0);
      send_byte(8'h12, 1'b1);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 49;
            end
            1: begin
               send_idle_pct = 49;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // long output stall while bytes keep coming
               hold_left = 150;
            end
         endcase
         phase_bytes = 0;
         while (phase_bytes < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                               : $urandom_range(1, 6);
            send_message(len);
            phase_bytes = phase_bytes + len;
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("sent %0d bytes in %0d messages; %0d characters checked",
               byte_count, msg_count, chars_checked);
      $display("idle mixes: sender-heavy, receiver-heavy, none with a long output stall");
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
src/b64enc_pkg.sv
src/b64enc_front.sv
src/b64enc_queue.sv
src/b64enc_back.sv
src/base64_stream_encoder.sv
test/b64_stream_checker.sv
test/tb_top.sv
